>>> rtl/cse_pkg.sv
`default_nettype none

package cse_pkg;

   // Field widths fixed by the interface.
   localparam int XWidth = 16;
   localparam int OutWidth = 24;

   // Internal fixed-point formats.
   localparam int MagWidth = XWidth + 1;
   localparam int YWidth = 31;
   localparam int AccWidth = 64;
   localparam int HalfWidth = AccWidth / 2;
   localparam int ProdWidth = HalfWidth + YWidth;
   localparam int OutShift = 36;
   localparam int ProdShift = 24;
   localparam int CoefCount = 20;
   localparam int MaxPowerDefault = 20;

   // Largest square of the magnitude: 8.0 squared, 24 fraction bits.
   localparam logic [YWidth-1:0] YMax = YWidth'(64'h4000_0000);

   // Data word carried from stage to stage.
   typedef struct packed {
      logic [YWidth-1:0]   y;
      logic [AccWidth-1:0] acc;
   } stage_type;

   // Coefficient 1/(2k)! rounded to nearest at 2^-48.
   function automatic logic [AccWidth-1:0] coef(input logic [4:0] k);
      logic [AccWidth-1:0] value;
      unique case (k)
         5'd0: value = 64'd281474976710656;
         5'd1: value = 64'd140737488355328;
         5'd2: value = 64'd11728124029611;
         5'd3: value = 64'd390937467654;
         5'd4: value = 64'd6981026208;
         5'd5: value = 64'd77566958;
         5'd6: value = 64'd587628;
         5'd7: value = 64'd3229;
         5'd8: value = 64'd13;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

>>> rtl/cse_if.sv
`default_nettype none

// Request channel: one argument word per handshake.
interface cse_req_if;
   logic valid;
   logic ready;
   logic signed [cse_pkg::XWidth-1:0] x_value;

   modport source (output valid, output x_value, input ready);
   modport sink (input valid, input x_value, output ready);
endinterface

// Response channel: one result word per handshake.
interface cse_rsp_if;
   logic valid;
   logic ready;
   logic [cse_pkg::OutWidth-1:0] cosh_value;

   modport source (output valid, output cosh_value, input ready);
   modport sink (input valid, input cosh_value, output ready);
endinterface

`default_nettype wire

>>> rtl/cse_square.sv
`default_nettype none

module cse_square #(
   parameter logic [cse_pkg::AccWidth-1:0] InitCoef = '0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   cse_req_if.sink           req_chan,
   output logic              down_valid,
   input  wire logic         down_ready,
   output cse_pkg::stage_type down_data
);

   logic                         valid_ff;
   logic                         valid_in;
   logic                         stage_ready;
   logic [cse_pkg::MagWidth-1:0] mag;
   logic [2*cse_pkg::MagWidth-1:0] square;
   cse_pkg::stage_type           data_ff;
   cse_pkg::stage_type           data_in;

   // The stage takes a word when it is empty or its word moves on.
   assign stage_ready = !valid_ff || down_ready;
   assign req_chan.ready = stage_ready;
   assign valid_in = req_chan.valid;

   // Magnitude of x; the most negative code gives exactly 8.0.
   always_comb begin
      if (req_chan.x_value[cse_pkg::XWidth-1]) begin
         mag = cse_pkg::MagWidth'(-$signed({req_chan.x_value[cse_pkg::XWidth-1],
                                            req_chan.x_value}));
      end else begin
         mag = cse_pkg::MagWidth'(req_chan.x_value);
      end
      square = mag * mag;
      data_in.y = square[cse_pkg::YWidth-1:0];
      data_in.acc = InitCoef;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready && valid_in) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data = data_ff;

endmodule

`default_nettype wire

>>> rtl/cse_horner_step.sv
`default_nettype none

module cse_horner_step #(
   parameter logic [cse_pkg::AccWidth-1:0] Coef = '0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   output logic                    up_ready,
   input  wire cse_pkg::stage_type up_data,
   output logic                    down_valid,
   input  wire logic               down_ready,
   output cse_pkg::stage_type      down_data
);

   localparam int HW = cse_pkg::HalfWidth;
   localparam int PW = cse_pkg::ProdWidth;
   localparam int AW = cse_pkg::AccWidth;
   localparam int PS = cse_pkg::ProdShift;
   localparam int UpShift = HW - PS;

   logic                      a_valid_ff;
   logic                      a_ready;
   logic [PW-1:0]             phi_ff;
   logic [PW-1:0]             phi_in;
   logic [PW-1:0]             plo_ff;
   logic [PW-1:0]             plo_in;
   logic [cse_pkg::YWidth-1:0] ya_ff;

   logic                      b_valid_ff;
   logic                      b_ready;
   cse_pkg::stage_type        b_data_ff;
   cse_pkg::stage_type        b_data_in;

   assign a_ready = !a_valid_ff || b_ready;
   assign b_ready = !b_valid_ff || down_ready;
   assign up_ready = a_ready;

   // First stage: two partial products of the accumulator halves with y.
   assign phi_in = PW'(up_data.acc[AW-1:HW]) * PW'(up_data.y);
   assign plo_in = PW'(up_data.acc[HW-1:0]) * PW'(up_data.y);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && up_valid) begin
         phi_ff <= phi_in;
         plo_ff <= plo_in;
         ya_ff <= up_data.y;
      end
   end

   // Second stage: align the halves, drop 24 fraction bits, add the coefficient.
   always_comb begin
      b_data_in.y = ya_ff;
      b_data_in.acc = {phi_ff[AW-UpShift-1:0], {UpShift{1'b0}}}
                    + AW'(plo_ff[PW-1:PS])
                    + Coef;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign down_valid = b_valid_ff;
   assign down_data = b_data_ff;

`ifndef SYNTH
   // A stalled product stage keeps its word.
   assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_ready |=> a_valid_ff && $stable(phi_ff) && $stable(plo_ff))
      else $error("product stage lost or changed a stalled word");

   // A stalled sum stage keeps its word.
   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !down_ready |=> b_valid_ff && $stable(b_data_ff))
      else $error("sum stage lost or changed a stalled word");

   // The square of a Q4.12 magnitude never exceeds 8.0 squared.
   assert property (@(posedge clock) disable iff (reset)
      up_valid |-> up_data.y <= cse_pkg::YMax)
      else $error("square out of range");

   // The partial sum stays below the saturation point.
   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> b_data_ff.acc[AW-1:cse_pkg::OutShift+cse_pkg::OutWidth] == '0)
      else $error("partial sum out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/cse_output.sv
`default_nettype none

module cse_output (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   output logic                    up_ready,
   input  wire cse_pkg::stage_type up_data,
   cse_rsp_if.source               rsp_chan
);

   localparam int AW = cse_pkg::AccWidth;
   localparam int OW = cse_pkg::OutWidth;
   localparam int OS = cse_pkg::OutShift;

   logic          valid_ff;
   logic          stage_ready;
   logic [OW-1:0] cosh_ff;
   logic [OW-1:0] cosh_in;

   assign stage_ready = !valid_ff || rsp_chan.ready;
   assign up_ready = stage_ready;

   // Truncate to 12 fraction bits and saturate at the top code.
   always_comb begin
      if (up_data.acc[AW-1:OS+OW] != '0) begin
         cosh_in = '1;
      end else begin
         cosh_in = up_data.acc[OS+OW-1:OS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready && up_valid) begin
         cosh_ff <= cosh_in;
      end
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.cosh_value = cosh_ff;

endmodule

`default_nettype wire

>>> rtl/cosh_series_evaluator.sv
// Channel   Direction  Word         Meaning
// req_chan  in         x_value      signed Q4.12 argument in [-8, 8)
// rsp_chan  out        cosh_value   truncated series cosh(x), unsigned Q12.12
//
// One word enters per cycle while the chain is not stalled; a result passes
// the square stage, the Horner chain and the output register in turn.
// Each Horner step is one product stage and one sum stage; the default is ten
// terms. Reset is synchronous and clears only the valid bits.
// Each stage stalls only when it is full and the stage after it is stalled,
// so empty slots are filled while the response side waits.
`default_nettype none

module cosh_series_evaluator #(
   parameter int MAX_POWER = cse_pkg::MaxPowerDefault
) (
   input wire logic  clock,
   input wire logic  reset,
   cse_req_if.sink   req_chan,
   cse_rsp_if.source rsp_chan
);

   localparam int TermRaw = (MAX_POWER + 1) / 2;
   localparam int TermCount = (TermRaw < 1) ? 1 :
                              ((TermRaw > cse_pkg::CoefCount) ? cse_pkg::CoefCount : TermRaw);
   localparam int StepCount = TermCount - 1;

   logic               chain_valid [StepCount+1];
   logic               chain_ready [StepCount+1];
   cse_pkg::stage_type chain_data  [StepCount+1];

   // Magnitude and square, accumulator loaded with the top coefficient.
   cse_square #(
      .InitCoef (cse_pkg::coef(5'(TermCount - 1)))
   ) u_square (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .down_valid (chain_valid[0]),
      .down_ready (chain_ready[0]),
      .down_data  (chain_data[0])
   );

   // One Horner step per remaining coefficient, highest first.
   for (genvar i = 0; i < StepCount; i++) begin : g_step
      cse_horner_step #(
         .Coef (cse_pkg::coef(5'(TermCount - 2 - i)))
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (chain_valid[i]),
         .up_ready   (chain_ready[i]),
         .up_data    (chain_data[i]),
         .down_valid (chain_valid[i+1]),
         .down_ready (chain_ready[i+1]),
         .down_data  (chain_data[i+1])
      );
   end

   // Output register with truncation and saturation.
   cse_output u_output (
      .clock    (clock),
      .reset    (reset),
      .up_valid (chain_valid[StepCount]),
      .up_ready (chain_ready[StepCount]),
      .up_data  (chain_data[StepCount]),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
